// ===== hw/rtl/owrs_pkg.sv =====
// shared types, codes and helpers for the 1-wire rom search engine
`default_nettype none
package owrs_pkg;

  // op codes of an input request
  localparam logic [2:0] OP_FIRST    = 3'd0;
  localparam logic [2:0] OP_NEXT     = 3'd1;
  localparam logic [2:0] OP_SKIP_FAM = 3'd2;
  localparam logic [2:0] OP_PRESENCE = 3'd3;
  localparam logic [2:0] OP_BIT_PAIR = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_BUS_RESET = 2'd0;
  localparam logic [1:0] KIND_SEND_CMD  = 2'd1;
  localparam logic [1:0] KIND_WRITE_BIT = 2'd2;
  localparam logic [1:0] KIND_FINISH    = 2'd3;

  localparam logic [7:0] SEARCH_CMD  = 8'hF0;
  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [6:0] ROM_BITS    = 7'd64;
  localparam logic [6:0] FAMILY_LIM  = 7'd9;
  localparam int         FIFO_DEPTH  = 4;
  localparam int         FIFO_AW     = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] family_code;
    logic       present;
    logic       id_bit;
    logic       complement_bit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  command_byte;
    logic        direction;
    logic        found;
    logic [63:0] device_rom;
    logic        last_device;
    logic        last_of_run;
  } out_item_t;

  // results caused by one accepted request, core to queue
  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
  } res_pair_t;

  function automatic out_item_t mk_res(input logic [1:0] kind, input logic [7:0] cmd,
                                       input logic dir, input logic fnd,
                                       input logic [63:0] rom, input logic last);
    out_item_t r;
    r.kind         = kind;
    r.command_byte = cmd;
    r.direction    = dir;
    r.found        = fnd;
    r.device_rom   = rom;
    r.last_device  = last;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/owrs_search_core.sv =====
// search state and per-request decision logic
`default_nettype none
module owrs_search_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire owrs_pkg::in_item_t req,
  output owrs_pkg::res_pair_t     results
);
  import owrs_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESENCE = 2'd1,
    PH_SEARCH   = 2'd2,
    PH_SPARE    = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [6:0]  ld_r, ld_nxt;
  logic [3:0]  fd_r, fd_nxt;
  logic        ldf_r, ldf_nxt;
  logic [63:0] rom_r, rom_nxt;
  logic [6:0]  bp_r, bp_nxt;
  logic [6:0]  lzp_r, lzp_nxt;
  logic [7:0]  crc_r, crc_nxt;

  logic        idle;
  logic [5:0]  sh;
  logic        dir;
  logic        fin_ok;

  assign idle = (phase_r != PH_PRESENCE) && (phase_r != PH_SEARCH);
  assign sh   = 6'(bp_r - 7'd1);

  // next state and results of one request
  always_comb begin
    phase_nxt = phase_r;
    ld_nxt    = ld_r;
    fd_nxt    = fd_r;
    ldf_nxt   = ldf_r;
    rom_nxt   = rom_r;
    bp_nxt    = bp_r;
    lzp_nxt   = lzp_r;
    crc_nxt   = crc_r;
    dir       = 1'b0;
    fin_ok    = 1'b0;
    results.count = 2'd0;
    results.res0  = mk_res(KIND_FINISH, 8'd0, 1'b0, 1'b0, 64'd0, 1'b0);
    results.res1  = mk_res(KIND_FINISH, 8'd0, 1'b0, 1'b0, 64'd0, 1'b0);

    if (req.op == OP_FIRST && idle) begin
      // first search, optionally targeted at one family
      if (req.family_code != 8'd0) begin
        rom_nxt = {56'd0, req.family_code};
        ld_nxt  = ROM_BITS;
      end else begin
        rom_nxt = 64'd0;
        ld_nxt  = 7'd0;
      end
      fd_nxt        = 4'd0;
      ldf_nxt       = 1'b0;
      phase_nxt     = PH_PRESENCE;
      results.count = 2'd1;
      results.res0  = mk_res(KIND_BUS_RESET, 8'd0, 1'b0, 1'b0, 64'd0, 1'b0);
    end else if (req.op == OP_NEXT && idle) begin
      results.count = 2'd1;
      if (ldf_r) begin
        ld_nxt  = 7'd0;
        fd_nxt  = 4'd0;
        ldf_nxt = 1'b0;
      end else begin
        phase_nxt    = PH_PRESENCE;
        results.res0 = mk_res(KIND_BUS_RESET, 8'd0, 1'b0, 1'b0, 64'd0, 1'b0);
      end
    end else if (req.op == OP_SKIP_FAM && idle) begin
      // resume from the family branch point
      ld_nxt = {3'd0, fd_r};
      fd_nxt = 4'd0;
      if (fd_r == 4'd0) begin
        ldf_nxt = 1'b1;
      end
    end else if (req.op == OP_PRESENCE && phase_r == PH_PRESENCE) begin
      results.count = 2'd1;
      if (!req.present) begin
        ld_nxt    = 7'd0;
        fd_nxt    = 4'd0;
        ldf_nxt   = 1'b0;
        phase_nxt = PH_IDLE;
      end else begin
        bp_nxt       = 7'd1;
        lzp_nxt      = 7'd0;
        crc_nxt      = 8'd0;
        phase_nxt    = PH_SEARCH;
        results.res0 = mk_res(KIND_SEND_CMD, SEARCH_CMD, 1'b0, 1'b0, 64'd0, 1'b0);
      end
    end else if (req.op == OP_BIT_PAIR && phase_r == PH_SEARCH) begin
      results.count = 2'd1;
      if (bp_r == 7'd0 || bp_r > ROM_BITS || (req.id_bit && req.complement_bit)) begin
        // no device answered, or position out of range
        ld_nxt    = 7'd0;
        fd_nxt    = 4'd0;
        ldf_nxt   = 1'b0;
        phase_nxt = PH_IDLE;
      end else begin
        // pick the direction for this position
        if (req.id_bit != req.complement_bit) begin
          dir = req.id_bit;
        end else begin
          if (bp_r < ld_r) begin
            dir = rom_r[sh];
          end else begin
            dir = (bp_r == ld_r);
          end
          if (!dir) begin
            lzp_nxt = bp_r;
            if (bp_r < FAMILY_LIM) begin
              fd_nxt = bp_r[3:0];
            end
          end
        end
        rom_nxt[sh]  = dir;
        // bitwise crc, matches the bytewise form at byte boundaries
        crc_nxt      = (crc_r >> 1) ^ ((crc_r[0] ^ dir) ? CRC_POLY : 8'd0);
        bp_nxt       = bp_r + 7'd1;
        results.res0 = mk_res(KIND_WRITE_BIT, 8'd0, dir, 1'b0, 64'd0, 1'b0);

        // last position: check crc and family byte
        if (bp_r == ROM_BITS) begin
          results.count = 2'd2;
          phase_nxt     = PH_IDLE;
          fin_ok        = (crc_nxt == 8'd0) && (rom_nxt[7:0] != 8'd0);
          if (fin_ok) begin
            ld_nxt       = lzp_nxt;
            ldf_nxt      = ldf_r | (lzp_nxt == 7'd0);
            results.res1 = mk_res(KIND_FINISH, 8'd0, 1'b0, 1'b1, rom_nxt, ldf_nxt);
          end else begin
            ld_nxt  = 7'd0;
            fd_nxt  = 4'd0;
            ldf_nxt = 1'b0;
          end
        end
      end
    end

    // mark the final result of this request
    if (results.count == 2'd2) begin
      results.res1.last_of_run = 1'b1;
    end else begin
      results.res0.last_of_run = 1'b1;
    end
  end

  // search state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      ld_r    <= 7'd0;
      fd_r    <= 4'd0;
      ldf_r   <= 1'b0;
      rom_r   <= 64'd0;
      bp_r    <= 7'd1;
      lzp_r   <= 7'd0;
      crc_r   <= 8'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      ld_r    <= ld_nxt;
      fd_r    <= fd_nxt;
      ldf_r   <= ldf_nxt;
      rom_r   <= rom_nxt;
      bp_r    <= bp_nxt;
      lzp_r   <= lzp_nxt;
      crc_r   <= crc_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/owrs_result_fifo.sv =====
// result queue: takes up to two results per cycle, hands out one
`default_nettype none
module owrs_result_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire owrs_pkg::res_pair_t push_data,
  output logic                     room2,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output owrs_pkg::out_item_t      out_data
);
  import owrs_pkg::*;

  out_item_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;
  logic [1:0]           n_push;
  logic                 pop;

  assign n_push    = push ? push_data.count : 2'd0;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];
  assign room2     = (cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign cnt_nxt   = cnt_r + (FIFO_AW+1)'(n_push) - (FIFO_AW+1)'(pop);

  // entry storage
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= push_data.res0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr_r + FIFO_AW'(1)] <= push_data.res1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(n_push);
      rd_ptr_r <= rd_ptr_r + FIFO_AW'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/one_wire_rom_search_engine.sv =====
// top level of the 1-wire rom search engine
`default_nettype none
// Master-side 1-wire ROM search. Each request (start, next, family skip,
// presence reply, bit pair) is decided in the cycle it is accepted; a new
// request can be accepted every cycle while the queue has room. Its one or
// two results (bus reset, send 0xF0, write direction, finish) go into a
// four-entry result queue and leave one per cycle while out_ready is high;
// in_ready is low while fewer than two queue entries are free, so the
// queue drain rate sets throughput once a consumer stalls. Requests in
// the wrong phase and unknown ops are accepted and produce no result.
module one_wire_rom_search_engine (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire owrs_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output owrs_pkg::out_item_t      out_data
);
  import owrs_pkg::*;

  res_pair_t results;
  logic      accept;
  logic      room2;

  assign in_ready = room2;
  assign accept   = in_valid && in_ready;

  // decision logic and search state
  owrs_search_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .req     (in_data),
    .results (results)
  );

  // result queue
  owrs_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (results),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the 1-wire rom search engine with a simulated device bus
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import owrs_pkg::*;

  localparam int NUM_REQUESTS = 650;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 20;

  // phase of the search as the predictor tracks it
  typedef enum logic [1:0] {
    SRCH_IDLE          = 2'd0,
    SRCH_WAIT_PRESENCE = 2'd1,
    SRCH_BITS          = 2'd2
  } search_phase_t;

  // rom search predictor and queue of expected results
  class rom_search_scoreboard;
    localparam int MAX_PRINTED = 40;

    logic [6:0]    last_disc;
    logic [3:0]    family_disc;
    logic          last_dev;
    logic [63:0]   rom;
    logic [6:0]    bit_pos;
    logic [6:0]    last_zero;
    logic [7:0]    crc;
    search_phase_t phase;
    out_item_t     expected_results[$];
    out_item_t     run_results[$];
    int            errors;
    int            checked;

    function new();
      last_disc   = '0;
      family_disc = '0;
      last_dev    = 1'b0;
      rom         = '0;
      bit_pos     = 7'd1;
      last_zero   = '0;
      crc         = '0;
      phase       = SRCH_IDLE;
      errors      = 0;
      checked     = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("error: %s", msg);
    endtask

    function int pending();
      return expected_results.size();
    endfunction

    static function logic [7:0] crc8_byte(logic [7:0] c, logic [7:0] v);
      logic mix;
      for (int i = 0; i < 8; i++) begin
        mix = c[0] ^ v[0];
        c = c >> 1;
        if (mix) c = c ^ CRC_POLY;
        v = v >> 1;
      end
      return c;
    endfunction

    function out_item_t make_result(logic [1:0] kind, logic [7:0] cmd, logic dir,
                                    logic fnd, logic [63:0] rom_val, logic last);
      out_item_t r;
      r.kind         = kind;
      r.command_byte = cmd;
      r.direction    = dir;
      r.found        = fnd;
      r.device_rom   = rom_val;
      r.last_device  = last;
      r.last_of_run  = 1'b0;
      return r;
    endfunction

    function void clear_search();
      last_disc   = '0;
      family_disc = '0;
      last_dev    = 1'b0;
    endfunction

    function void push_failure();
      run_results.push_back(make_result(KIND_FINISH, 8'd0, 1'b0, 1'b0, 64'd0, 1'b0));
    endfunction

    // a search after the last device finishes at once without bus traffic
    function void begin_search();
      if (last_dev) begin
        clear_search();
        push_failure();
      end else begin
        phase = SRCH_WAIT_PRESENCE;
        run_results.push_back(make_result(KIND_BUS_RESET, 8'd0, 1'b0, 1'b0, 64'd0, 1'b0));
      end
    endfunction

    // one id/complement pair: pick direction, track discrepancies and crc
    function void take_bit_pair(logic id_b, logic cmp_b);
      int   p;
      logic dir;
      bit   found_ok;
      p = int'(bit_pos);
      if ((id_b && cmp_b) || p < 1 || p > int'(ROM_BITS)) begin
        clear_search();
        phase = SRCH_IDLE;
        push_failure();
        return;
      end
      if (id_b != cmp_b) begin
        dir = id_b;
      end else begin
        if (p < last_disc) dir = rom[p-1];
        else dir = (p == last_disc);
        if (!dir) begin
          last_zero = 7'(p);
          if (p < FAMILY_LIM) family_disc = 4'(p);
        end
      end
      rom[p-1] = dir;
      run_results.push_back(make_result(KIND_WRITE_BIT, 8'd0, dir, 1'b0, 64'd0, 1'b0));
      if (p % 8 == 0) crc = crc8_byte(crc, rom[p-8 +: 8]);
      bit_pos = 7'(p + 1);
      if (p < int'(ROM_BITS)) return;
      // all 64 bits in: check crc and family byte
      phase    = SRCH_IDLE;
      found_ok = 1'b0;
      if (crc == 8'd0) begin
        last_disc = last_zero;
        if (last_disc == 7'd0) last_dev = 1'b1;
        found_ok = (rom[7:0] != 8'd0);
      end
      if (found_ok) begin
        run_results.push_back(make_result(KIND_FINISH, 8'd0, 1'b0, 1'b1, rom, last_dev));
      end else begin
        clear_search();
        push_failure();
      end
    endfunction

    // returns 1 when the request is not ignored by the engine
    function bit note_request(in_item_t r);
      logic      idle;
      out_item_t tail;
      idle = (phase != SRCH_WAIT_PRESENCE) && (phase != SRCH_BITS);
      run_results.delete();
      if (r.op == OP_FIRST && idle) begin
        rom         = (r.family_code != 8'd0) ? {56'd0, r.family_code} : 64'd0;
        last_disc   = (r.family_code != 8'd0) ? ROM_BITS : 7'd0;
        family_disc = '0;
        last_dev    = 1'b0;
        begin_search();
      end else if (r.op == OP_NEXT && idle) begin
        begin_search();
      end else if (r.op == OP_SKIP_FAM && idle) begin
        last_disc   = {3'd0, family_disc};
        family_disc = '0;
        if (last_disc == 7'd0) last_dev = 1'b1;
      end else if (r.op == OP_PRESENCE && phase == SRCH_WAIT_PRESENCE) begin
        if (!r.present) begin
          clear_search();
          phase = SRCH_IDLE;
          push_failure();
        end else begin
          bit_pos   = 7'd1;
          last_zero = '0;
          crc       = '0;
          phase     = SRCH_BITS;
          run_results.push_back(make_result(KIND_SEND_CMD, SEARCH_CMD, 1'b0, 1'b0, 64'd0,
                                            1'b0));
        end
      end else if (r.op == OP_BIT_PAIR && phase == SRCH_BITS) begin
        take_bit_pair(r.id_bit, r.complement_bit);
      end else begin
        return 1'b0;
      end
      // mark the final result of this request
      if (run_results.size() > 0) begin
        tail = run_results.pop_back();
        tail.last_of_run = 1'b1;
        run_results.push_back(tail);
      end
      foreach (run_results[i]) expected_results.push_back(run_results[i]);
      return 1'b1;
    endfunction

    task compare_field(string name, logic [63:0] got_v, logic [63:0] want_v);
      if (got_v !== want_v)
        report($sformatf("result %0d %s got %h want %h", checked, name, got_v, want_v));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (expected_results.size() == 0) begin
        report($sformatf("result %0d kind %0d arrived with nothing expected",
                         checked, got.kind));
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind", 64'(got.kind), 64'(want.kind));
      compare_field("command_byte", 64'(got.command_byte), 64'(want.command_byte));
      compare_field("direction", 64'(got.direction), 64'(want.direction));
      compare_field("found", 64'(got.found), 64'(want.found));
      compare_field("device_rom", got.device_rom, want.device_rom);
      compare_field("last_device", 64'(got.last_device), 64'(want.last_device));
      compare_field("last_of_run", 64'(got.last_of_run), 64'(want.last_of_run));
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  rom_search_scoreboard sb;
  logic [63:0] bus_devs[$];
  int idle_pct    = 0;
  int stall_pct   = 0;
  int n_eff       = 0;
  int idle_cycles = 0;

  one_wire_rom_search_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // result side: check accepted results, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // present one request, wait for acceptance, update the predictor
  task automatic send_req(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_request(it)) n_eff++;
  endtask

  task automatic send_fields(input logic [2:0] op, input logic [7:0] fam, input logic pres,
                             input logic id_b, input logic cmp_b);
    in_item_t it;
    it.op             = op;
    it.family_code    = fam;
    it.present        = pres;
    it.id_bit         = id_b;
    it.complement_bit = cmp_b;
    send_req(it);
  endtask

  // sender holds off until every expected result is in
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic in_item_t random_item();
    in_item_t r;
    r.op             = 3'($urandom_range(7));
    r.family_code    = 8'($urandom_range(255));
    r.present        = 1'($urandom_range(1));
    r.id_bit         = 1'($urandom_range(1));
    r.complement_bit = 1'($urandom_range(1));
    return r;
  endfunction

  // device rom: mostly valid, some with zero family or corrupted crc
  function automatic logic [63:0] make_device();
    logic [63:0] d;
    logic [7:0]  c;
    int          flavor;
    d[39:8]  = $urandom;
    d[55:40] = 16'($urandom_range(65535));
    case ($urandom_range(4))
      0: d[7:0] = 8'h28;
      1: d[7:0] = 8'h29;
      2: d[7:0] = 8'h10;
      default: d[7:0] = 8'($urandom_range(255));
    endcase
    flavor = $urandom_range(19);
    if (flavor == 0) d[7:0] = 8'h00;
    c = 8'h00;
    for (int i = 0; i < 7; i++) c = rom_search_scoreboard::crc8_byte(c, d[8*i +: 8]);
    d[63:56] = c;
    if (flavor == 1) d[63:56] = c ^ (8'h01 << $urandom_range(7));
    return d;
  endfunction

  // answer presence and bit pairs as a wired-and bus until the search ends
  task automatic finish_search();
    in_item_t    it;
    logic [63:0] mask;
    int          p;
    while (sb.phase == SRCH_WAIT_PRESENCE || sb.phase == SRCH_BITS) begin
      it = random_item();
      if ($urandom_range(24) == 0) begin
        // stray request, mostly out of phase
      end else if (sb.phase == SRCH_WAIT_PRESENCE) begin
        it.op      = OP_PRESENCE;
        it.present = ($urandom_range(11) != 0);
      end else begin
        it.op = OP_BIT_PAIR;
        // rare bus glitch keeps the random pair
        if ($urandom_range(299) != 0) begin
          p                 = int'(sb.bit_pos);
          mask              = (64'd1 << (p - 1)) - 64'd1;
          it.id_bit         = 1'b1;
          it.complement_bit = 1'b1;
          foreach (bus_devs[i]) begin
            if (((bus_devs[i] ^ sb.rom) & mask) == 64'd0) begin
              it.id_bit         = it.id_bit & bus_devs[i][p-1];
              it.complement_bit = it.complement_bit & ~bus_devs[i][p-1];
            end
          end
        end
      end
      send_req(it);
    end
  endtask

  // one bus population: first search, then next searches until the last device
  task automatic run_episode();
    in_item_t it;
    int       n_dev;
    int       rounds;
    bit       was_last;
    bus_devs.delete();
    n_dev = $urandom_range(1, 4);
    repeat (n_dev) bus_devs.push_back(make_device());
    it    = random_item();
    it.op = OP_FIRST;
    case ($urandom_range(9))
      0, 1: it.family_code = bus_devs[$urandom_range(n_dev - 1)][7:0];
      2: it.family_code = 8'($urandom_range(255));
      default: it.family_code = 8'h00;
    endcase
    send_req(it);
    finish_search();
    rounds = 0;
    do begin
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 3)) send_req(random_item());
        finish_search();
      end
      if ($urandom_range(5) == 0) begin
        it    = random_item();
        it.op = OP_SKIP_FAM;
        send_req(it);
      end
      was_last = sb.last_dev;
      it       = random_item();
      it.op    = OP_NEXT;
      send_req(it);
      finish_search();
      rounds++;
    end while (!was_last && rounds <= n_dev);
  endtask

  // short directed sequence over ops, phases and special cases
  task automatic run_directed();
    // unknown ops and out-of-phase requests at idle
    send_fields(3'd5, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_fields(3'd6, 8'h00, 1'b0, 1'b0, 1'b0);
    send_fields(3'd7, 8'h5A, 1'b1, 1'b0, 1'b1);
    send_fields(OP_PRESENCE, 8'h00, 1'b1, 1'b0, 1'b0);
    send_fields(OP_BIT_PAIR, 8'h00, 1'b0, 1'b1, 1'b1);
    // family skip with no discrepancy, then next search after the last device
    send_fields(OP_SKIP_FAM, 8'h00, 1'b0, 1'b0, 1'b0);
    send_fields(OP_NEXT, 8'h00, 1'b0, 1'b0, 1'b0);
    // search with no presence pulse
    send_fields(OP_FIRST, 8'h00, 1'b0, 1'b0, 1'b0);
    send_fields(OP_FIRST, 8'h7F, 1'b1, 1'b0, 1'b0);
    send_fields(OP_BIT_PAIR, 8'h00, 1'b1, 1'b0, 1'b0);
    send_fields(OP_PRESENCE, 8'hFF, 1'b0, 1'b1, 1'b1);
    // targeted search, out-of-phase ops, pairs ending in a 1/1 pair
    send_fields(OP_FIRST, 8'hFF, 1'b0, 1'b0, 1'b0);
    send_fields(OP_PRESENCE, 8'h00, 1'b1, 1'b0, 1'b0);
    send_fields(OP_NEXT, 8'h00, 1'b1, 1'b0, 1'b0);
    send_fields(OP_SKIP_FAM, 8'h00, 1'b1, 1'b0, 1'b0);
    send_fields(OP_PRESENCE, 8'h00, 1'b0, 1'b0, 1'b0);
    send_fields(OP_BIT_PAIR, 8'h00, 1'b0, 1'b0, 1'b1);
    send_fields(OP_BIT_PAIR, 8'hFF, 1'b1, 1'b1, 1'b0);
    send_fields(OP_BIT_PAIR, 8'h00, 1'b0, 1'b0, 1'b0);
    send_fields(OP_BIT_PAIR, 8'h00, 1'b0, 1'b1, 1'b1);
    // plain next search, discrepancy at bit one, then 1/1
    send_fields(OP_NEXT, 8'h00, 1'b0, 1'b0, 1'b0);
    send_fields(OP_PRESENCE, 8'h00, 1'b1, 1'b0, 1'b0);
    send_fields(OP_BIT_PAIR, 8'h00, 1'b0, 1'b0, 1'b0);
    send_fields(OP_BIT_PAIR, 8'h00, 1'b0, 1'b1, 1'b1);
  endtask

  // main sequence
  initial begin
    int base;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    drain_results();
    base = n_eff;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 56 : (ph == 3) ? 25 : 0;
      stall_pct = (ph == 2) ? 56 : (ph == 3) ? 25 : 0;
      while (n_eff < base + NUM_REQUESTS * (ph + 1) / 4) run_episode();
      drain_results();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
